[src/lts_pkg.sv]
`default_nettype none

package lts_pkg;

    typedef enum logic [3:0] {
        KIND_IDENT = 4'd0,
        KIND_INT   = 4'd1,
        KIND_FLOAT = 4'd2,
        KIND_BEGIN = 4'd3,
        KIND_END   = 4'd4,
        KIND_IF    = 4'd5,
        KIND_THEN  = 4'd6,
        KIND_ELSE  = 4'd7,
        KIND_LT    = 4'd8,
        KIND_LE    = 4'd9,
        KIND_EQ    = 4'd10,
        KIND_NE    = 4'd11,
        KIND_GT    = 4'd12,
        KIND_GE    = 4'd13,
        KIND_ERROR = 4'd14
    } t_kind;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_INT,
        MODE_FLOAT,
        MODE_LT,
        MODE_GT
    } t_mode;

    typedef enum logic [3:0] {
        CLS_LETTER,
        CLS_DIGIT,
        CLS_DOT,
        CLS_LT,
        CLS_GT,
        CLS_EQ,
        CLS_BLANK,
        CLS_OTHER,
        CLS_END
    } t_cls;

    typedef struct packed {
        t_cls       cls;
        logic [7:0] code;
    } t_cmd;

    typedef enum logic [1:0] {
        BS_READY,
        BS_FETCH,
        BS_EMIT,
        BS_APPLY
    } t_bstate;

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_EQ      = 8'h3D;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NL      = 8'h0A;

    localparam int NUM_KW = 5;

    // Keyword spellings, padded with zeros to eight characters.
    localparam logic [7:0] KW_TEXT [NUM_KW][8] = '{
        '{8'h62, 8'h65, 8'h67, 8'h69, 8'h6E, 8'h00, 8'h00, 8'h00},
        '{8'h65, 8'h6E, 8'h64, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h69, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h74, 8'h68, 8'h65, 8'h6E, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h65, 8'h6C, 8'h73, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd5, 3'd3, 3'd2, 3'd4, 3'd4};

    localparam t_kind KW_KIND [NUM_KW] = '{KIND_BEGIN, KIND_END, KIND_IF, KIND_THEN, KIND_ELSE};

endpackage

`default_nettype wire

[src/lts_ifs.sv]
`default_nettype none

interface lts_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_input;

    modport source(output valid, output char_code, output end_of_input, input ready);
    modport sink(input valid, input char_code, input end_of_input, output ready);
endinterface

interface lts_out_if;
    logic          valid;
    logic          ready;
    lts_pkg::t_kind token_kind;
    logic [7:0]    char_value;
    logic          last_of_run;
    logic          truncated;

    modport source(output valid, output token_kind, output char_value, output last_of_run,
                   output truncated, input ready);
    modport sink(input valid, input token_kind, input char_value, input last_of_run,
                 input truncated, output ready);
endinterface

`default_nettype wire

[src/lexical_token_scanner.sv]
// Scans a character stream into identifiers, the keywords begin/end/if/then/else, integers,
// floats and relational operators, one request per character; a request with end_of_input set
// flushes the pending token. Each token leaves as a run of results with one text character each
// and last_of_run on the final one; operators and errors are single results with a zero
// character. A front stage classifies characters into a two-entry queue, and a back sequencer
// executes them: a character that extends a token or completes a two-character operator is
// taken in the READY state, and any other character is then applied in the APPLY state. A
// flush reads each stored character via FETCH and EMIT; the token buffer has a registered read.
// The sequencer waits while its result register holds a result that has not been taken. Text
// beyond MAX_TOKEN_CHARS characters is dropped and the token's results carry truncated.
`default_nettype none

module lexical_token_scanner #(
    parameter int MAX_TOKEN_CHARS = 19
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    lts_in_if.sink    i_req,
    lts_out_if.source o_res
);

    lts_pkg::t_cmd w_cmd;
    logic          w_cmd_valid;
    logic          w_cmd_pop;

    lts_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_cmd       (w_cmd),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_pop   (w_cmd_pop)
    );

    lts_back #(
        .MAX_TOKEN_CHARS (MAX_TOKEN_CHARS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_pop   (w_cmd_pop),
        .o_res       (o_res)
    );

endmodule

`default_nettype wire

[src/lts_front.sv]
`default_nettype none

module lts_front (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    lts_in_if.sink        i_req,
    output lts_pkg::t_cmd o_cmd,
    output logic          o_cmd_valid,
    input  wire logic     i_cmd_pop
);

    lts_pkg::t_cmd w_cmd;
    lts_pkg::t_cmd r_q [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    logic          w_push;
    logic          w_pop;
    logic [7:0]    w_c;

    assign w_c = i_req.char_code;

    always_comb begin
        w_cmd.code = w_c;
        if (i_req.end_of_input) begin
            w_cmd.cls = lts_pkg::CLS_END;
        end else if ((w_c >= lts_pkg::CH_LOWER_A && w_c <= lts_pkg::CH_LOWER_Z) ||
                     (w_c >= lts_pkg::CH_UPPER_A && w_c <= lts_pkg::CH_UPPER_Z)) begin
            w_cmd.cls = lts_pkg::CLS_LETTER;
        end else if (w_c >= lts_pkg::CH_ZERO && w_c <= lts_pkg::CH_NINE) begin
            w_cmd.cls = lts_pkg::CLS_DIGIT;
        end else if (w_c == lts_pkg::CH_DOT) begin
            w_cmd.cls = lts_pkg::CLS_DOT;
        end else if (w_c == lts_pkg::CH_LT) begin
            w_cmd.cls = lts_pkg::CLS_LT;
        end else if (w_c == lts_pkg::CH_GT) begin
            w_cmd.cls = lts_pkg::CLS_GT;
        end else if (w_c == lts_pkg::CH_EQ) begin
            w_cmd.cls = lts_pkg::CLS_EQ;
        end else if (w_c == lts_pkg::CH_SPACE || w_c == lts_pkg::CH_TAB ||
                     w_c == lts_pkg::CH_NL) begin
            w_cmd.cls = lts_pkg::CLS_BLANK;
        end else begin
            w_cmd.cls = lts_pkg::CLS_OTHER;
        end
    end

    assign i_req.ready = (r_cnt != 2'd2);
    assign w_push      = i_req.valid && i_req.ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign w_pop       = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (w_pop) begin
                r_rp <= !r_rp;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2)
        else $error("Request queue count out of range.");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_cnt == $past(r_cnt) + 2'd1))
        else $error("Request queue count did not grow on a push.");

endmodule

`default_nettype wire

[src/lts_back.sv]
`default_nettype none

module lts_back #(
    parameter int MAX_TOKEN_CHARS = 19
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire lts_pkg::t_cmd i_cmd,
    input  wire logic          i_cmd_valid,
    output logic               o_cmd_pop,
    lts_out_if.source          o_res
);

    localparam int LW = $clog2(MAX_TOKEN_CHARS + 1);
    localparam int IW = $clog2(MAX_TOKEN_CHARS);
    localparam int NK = lts_pkg::NUM_KW;

    lts_pkg::t_bstate r_state, n_state;
    lts_pkg::t_mode   r_mode, n_mode;
    logic [LW-1:0]    r_len, n_len;
    logic             r_ovf, n_ovf;
    logic [NK-1:0]    r_kw_ok, n_kw_ok;
    logic [IW-1:0]    r_idx, n_idx;
    lts_pkg::t_cmd    r_cur, n_cur;
    lts_pkg::t_kind   r_kind, n_kind;
    logic [7:0]       r_rd;
    logic [7:0]       r_buf [MAX_TOKEN_CHARS];

    logic             r_out_valid, n_out_valid;
    lts_pkg::t_kind   r_out_kind;
    logic [7:0]       r_out_char;
    logic             r_out_last;
    logic             r_out_trunc;

    logic             w_slot_free;
    logic             w_emit;
    lts_pkg::t_kind   w_ekind;
    logic [7:0]       w_echar;
    logic             w_elast;
    logic             w_etrunc;
    logic             w_store;
    logic             w_sfresh;
    logic             w_we;
    logic             w_last;
    lts_pkg::t_kind   w_id_kind;
    logic [NK-1:0]    w_kw_base;

    assign w_slot_free = !r_out_valid || o_res.ready;
    assign w_last      = ((LW'(r_idx) + LW'(1)) == r_len);

    always_comb begin
        w_id_kind = lts_pkg::KIND_IDENT;
        for (int k = 0; k < NK; k++) begin
            if (!r_ovf && r_kw_ok[k] && r_len == LW'(lts_pkg::KW_LEN[k])) begin
                w_id_kind = lts_pkg::KW_KIND[k];
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_len       = r_len;
        n_ovf       = r_ovf;
        n_kw_ok     = r_kw_ok;
        n_idx       = r_idx;
        n_cur       = r_cur;
        n_kind      = r_kind;
        o_cmd_pop   = 1'b0;
        w_emit      = 1'b0;
        w_ekind     = lts_pkg::KIND_ERROR;
        w_echar     = 8'd0;
        w_elast     = 1'b1;
        w_etrunc    = 1'b0;
        w_store     = 1'b0;
        w_sfresh    = 1'b0;
        w_we        = 1'b0;
        w_kw_base   = r_kw_ok;

        unique case (r_state)
            lts_pkg::BS_READY: begin
                if (i_cmd_valid && w_slot_free) begin
                    o_cmd_pop = 1'b1;
                    n_cur     = i_cmd;
                    unique case (r_mode)
                        lts_pkg::MODE_IDENT: begin
                            if (i_cmd.cls == lts_pkg::CLS_LETTER ||
                                i_cmd.cls == lts_pkg::CLS_DIGIT) begin
                                w_store = 1'b1;
                            end else begin
                                n_state = lts_pkg::BS_FETCH;
                            end
                        end
                        lts_pkg::MODE_INT: begin
                            if (i_cmd.cls == lts_pkg::CLS_DIGIT) begin
                                w_store = 1'b1;
                            end else if (i_cmd.cls == lts_pkg::CLS_DOT) begin
                                w_store = 1'b1;
                                n_mode  = lts_pkg::MODE_FLOAT;
                            end else begin
                                n_state = lts_pkg::BS_FETCH;
                            end
                        end
                        lts_pkg::MODE_FLOAT: begin
                            if (i_cmd.cls == lts_pkg::CLS_DIGIT) begin
                                w_store = 1'b1;
                            end else begin
                                n_state = lts_pkg::BS_FETCH;
                            end
                        end
                        lts_pkg::MODE_LT: begin
                            w_emit = 1'b1;
                            n_mode = lts_pkg::MODE_IDLE;
                            if (i_cmd.cls == lts_pkg::CLS_EQ) begin
                                w_ekind = lts_pkg::KIND_LE;
                            end else if (i_cmd.cls == lts_pkg::CLS_GT) begin
                                w_ekind = lts_pkg::KIND_NE;
                            end else begin
                                w_ekind = lts_pkg::KIND_LT;
                                n_state = lts_pkg::BS_APPLY;
                            end
                        end
                        lts_pkg::MODE_GT: begin
                            w_emit = 1'b1;
                            n_mode = lts_pkg::MODE_IDLE;
                            if (i_cmd.cls == lts_pkg::CLS_EQ) begin
                                w_ekind = lts_pkg::KIND_GE;
                            end else begin
                                w_ekind = lts_pkg::KIND_GT;
                                n_state = lts_pkg::BS_APPLY;
                            end
                        end
                        default: begin
                            n_mode  = lts_pkg::MODE_IDLE;
                            n_state = lts_pkg::BS_APPLY;
                        end
                    endcase
                    if (n_state == lts_pkg::BS_FETCH) begin
                        n_idx  = '0;
                        n_mode = lts_pkg::MODE_IDLE;
                        if (r_mode == lts_pkg::MODE_IDENT) begin
                            n_kind = w_id_kind;
                        end else if (r_mode == lts_pkg::MODE_INT) begin
                            n_kind = lts_pkg::KIND_INT;
                        end else begin
                            n_kind = lts_pkg::KIND_FLOAT;
                        end
                    end
                end
            end
            lts_pkg::BS_FETCH: begin
                n_state = lts_pkg::BS_EMIT;
            end
            lts_pkg::BS_EMIT: begin
                if (w_slot_free) begin
                    w_emit   = 1'b1;
                    w_ekind  = r_kind;
                    w_echar  = r_rd;
                    w_elast  = w_last;
                    w_etrunc = r_ovf;
                    if (w_last) begin
                        n_len   = '0;
                        n_ovf   = 1'b0;
                        n_state = lts_pkg::BS_APPLY;
                    end else begin
                        n_idx   = IW'(LW'(r_idx) + LW'(1));
                        n_state = lts_pkg::BS_FETCH;
                    end
                end
            end
            lts_pkg::BS_APPLY: begin
                if (w_slot_free) begin
                    n_state = lts_pkg::BS_READY;
                    unique case (r_cur.cls) inside
                        lts_pkg::CLS_LETTER: begin
                            n_mode   = lts_pkg::MODE_IDENT;
                            w_store  = 1'b1;
                            w_sfresh = 1'b1;
                        end
                        lts_pkg::CLS_DIGIT: begin
                            n_mode   = lts_pkg::MODE_INT;
                            w_store  = 1'b1;
                            w_sfresh = 1'b1;
                        end
                        lts_pkg::CLS_LT: begin
                            n_mode = lts_pkg::MODE_LT;
                        end
                        lts_pkg::CLS_GT: begin
                            n_mode = lts_pkg::MODE_GT;
                        end
                        lts_pkg::CLS_EQ: begin
                            w_emit  = 1'b1;
                            w_ekind = lts_pkg::KIND_EQ;
                        end
                        lts_pkg::CLS_BLANK, lts_pkg::CLS_END: begin
                        end
                        default: begin
                            w_emit  = 1'b1;
                            w_ekind = lts_pkg::KIND_ERROR;
                        end
                    endcase
                end
            end
            default: begin
                n_state = lts_pkg::BS_READY;
            end
        endcase

        if (w_sfresh) begin
            w_kw_base = '1;
        end
        if (w_store) begin
            if (r_len < LW'(MAX_TOKEN_CHARS)) begin
                w_we  = 1'b1;
                n_len = r_len + LW'(1);
                for (int k = 0; k < NK; k++) begin
                    n_kw_ok[k] = w_kw_base[k] && (r_len < LW'(lts_pkg::KW_LEN[k])) &&
                                 (n_cur.code == lts_pkg::KW_TEXT[k][r_len[2:0]]);
                end
            end else begin
                n_ovf = 1'b1;
            end
        end

        if (w_emit) begin
            n_out_valid = 1'b1;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_buf[r_len[IW-1:0]] <= n_cur.code;
        end
        r_rd <= r_buf[r_idx];
    end

    always_ff @(posedge i_clk) begin
        r_kw_ok <= n_kw_ok;
        r_idx   <= n_idx;
        r_cur   <= n_cur;
        r_kind  <= n_kind;
        if (w_emit) begin
            r_out_kind  <= w_ekind;
            r_out_char  <= w_echar;
            r_out_last  <= w_elast;
            r_out_trunc <= w_etrunc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lts_pkg::BS_READY;
            r_mode      <= lts_pkg::MODE_IDLE;
            r_len       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_len       <= n_len;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.token_kind  = r_out_kind;
    assign o_res.char_value  = r_out_char;
    assign o_res.last_of_run = r_out_last;
    assign o_res.truncated   = r_out_trunc;

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(MAX_TOKEN_CHARS))
        else $error("Token length exceeds the buffer.");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_len == LW'(MAX_TOKEN_CHARS)))
        else $error("Overflow flagged while the buffer is not full.");

    a_emit_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lts_pkg::BS_EMIT) |-> (LW'(r_idx) < r_len))
        else $error("Token read index beyond the stored length.");

endmodule

`default_nettype wire

[tb/sv/lexical_token_scanner_tb.sv]
`default_nettype none

module lexical_token_scanner_tb;

    localparam int MAX_TOKEN_CHARS = 19;
    localparam int RANDOM_REQUESTS = 400;
    localparam int SETTLE_CYCLES   = 64;
    localparam int CYCLE_LIMIT     = 300000;

    typedef struct {
        lts_pkg::t_kind kind;
        logic [7:0]     ch;
        logic           last;
        logic           trunc;
    } t_token_result;

    typedef struct {
        logic [7:0] code;
        bit         eoi;
        bit         drain;
    } t_char_request;

    class token_tracker;
        lts_pkg::t_mode mode;
        logic [7:0]     text [MAX_TOKEN_CHARS];
        int             length;
        bit             overflow;
        t_token_result  pending_tokens[$];
        int             chars_taken;
        int             results_checked;
        int             truncated_results;
        bit [15:0]      kinds_seen;
        int             mismatches;

        function new();
            mode = lts_pkg::MODE_IDLE;
            length = 0;
            overflow = 1'b0;
            chars_taken = 0;
            results_checked = 0;
            truncated_results = 0;
            kinds_seen = '0;
            mismatches = 0;
        endfunction

        function bit is_letter(logic [7:0] c);
            return (c >= lts_pkg::CH_LOWER_A && c <= lts_pkg::CH_LOWER_Z) ||
                   (c >= lts_pkg::CH_UPPER_A && c <= lts_pkg::CH_UPPER_Z);
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= lts_pkg::CH_ZERO && c <= lts_pkg::CH_NINE;
        endfunction

        function void expect_result(lts_pkg::t_kind kind, logic [7:0] ch, logic last,
                                    logic trunc);
            t_token_result r;
            r.kind = kind;
            r.ch = ch;
            r.last = last;
            r.trunc = trunc;
            pending_tokens.push_back(r);
        endfunction

        function void store_char(logic [7:0] c);
            if (length < MAX_TOKEN_CHARS) begin
                text[length] = c;
                length++;
            end else begin
                overflow = 1'b1;
            end
        endfunction

        function lts_pkg::t_kind word_kind();
            string          words [5];
            lts_pkg::t_kind kinds [5];
            bit             hit;
            int             k;
            int             i;
            words = '{"begin", "end", "if", "then", "else"};
            kinds = '{lts_pkg::KIND_BEGIN, lts_pkg::KIND_END, lts_pkg::KIND_IF,
                      lts_pkg::KIND_THEN, lts_pkg::KIND_ELSE};
            if (overflow) return lts_pkg::KIND_IDENT;
            for (k = 0; k < 5; k++) begin
                if (words[k].len() == length) begin
                    hit = 1'b1;
                    for (i = 0; i < length; i++) begin
                        if (text[i] != 8'(words[k][i])) hit = 1'b0;
                    end
                    if (hit) return kinds[k];
                end
            end
            return lts_pkg::KIND_IDENT;
        endfunction

        function void close_token();
            lts_pkg::t_kind kind;
            int             i;
            case (mode)
                lts_pkg::MODE_LT: expect_result(lts_pkg::KIND_LT, 8'h00, 1'b1, 1'b0);
                lts_pkg::MODE_GT: expect_result(lts_pkg::KIND_GT, 8'h00, 1'b1, 1'b0);
                lts_pkg::MODE_IDENT, lts_pkg::MODE_INT, lts_pkg::MODE_FLOAT: begin
                    if (mode == lts_pkg::MODE_IDENT) kind = word_kind();
                    else if (mode == lts_pkg::MODE_INT) kind = lts_pkg::KIND_INT;
                    else kind = lts_pkg::KIND_FLOAT;
                    for (i = 0; i < length; i++) begin
                        expect_result(kind, text[i], i == length - 1, overflow);
                    end
                end
                default: ;
            endcase
            mode = lts_pkg::MODE_IDLE;
            length = 0;
            overflow = 1'b0;
        endfunction

        function void open_token(logic [7:0] c);
            if (is_letter(c)) begin
                mode = lts_pkg::MODE_IDENT;
                store_char(c);
            end else if (is_digit(c)) begin
                mode = lts_pkg::MODE_INT;
                store_char(c);
            end else if (c == lts_pkg::CH_LT) begin
                mode = lts_pkg::MODE_LT;
            end else if (c == lts_pkg::CH_GT) begin
                mode = lts_pkg::MODE_GT;
            end else if (c == lts_pkg::CH_EQ) begin
                expect_result(lts_pkg::KIND_EQ, 8'h00, 1'b1, 1'b0);
            end else if (!(c == lts_pkg::CH_SPACE || c == lts_pkg::CH_TAB ||
                           c == lts_pkg::CH_NL)) begin
                expect_result(lts_pkg::KIND_ERROR, 8'h00, 1'b1, 1'b0);
            end
        endfunction

        // A character that cannot extend the pending token closes it and is then
        // scanned again from the idle state.
        function void take_char(logic [7:0] c, bit eoi);
            chars_taken++;
            if (eoi) begin
                close_token();
                return;
            end
            case (mode)
                lts_pkg::MODE_IDENT: begin
                    if (is_letter(c) || is_digit(c)) begin
                        store_char(c);
                        return;
                    end
                end
                lts_pkg::MODE_INT: begin
                    if (is_digit(c) || c == lts_pkg::CH_DOT) begin
                        if (c == lts_pkg::CH_DOT) mode = lts_pkg::MODE_FLOAT;
                        store_char(c);
                        return;
                    end
                end
                lts_pkg::MODE_FLOAT: begin
                    if (is_digit(c)) begin
                        store_char(c);
                        return;
                    end
                end
                lts_pkg::MODE_LT: begin
                    if (c == lts_pkg::CH_EQ || c == lts_pkg::CH_GT) begin
                        expect_result((c == lts_pkg::CH_EQ) ? lts_pkg::KIND_LE : lts_pkg::KIND_NE,
                                      8'h00, 1'b1, 1'b0);
                        mode = lts_pkg::MODE_IDLE;
                        return;
                    end
                end
                lts_pkg::MODE_GT: begin
                    if (c == lts_pkg::CH_EQ) begin
                        expect_result(lts_pkg::KIND_GE, 8'h00, 1'b1, 1'b0);
                        mode = lts_pkg::MODE_IDLE;
                        return;
                    end
                end
                default: ;
            endcase
            close_token();
            open_token(c);
        endfunction

        function void check_token_result(lts_pkg::t_kind kind, logic [7:0] ch, logic last,
                                         logic trunc);
            t_token_result want;
            results_checked++;
            if (!$isunknown(kind)) kinds_seen[kind] = 1'b1;
            if (trunc === 1'b1) truncated_results++;
            if (pending_tokens.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result: kind %0d char %h last %b trunc %b",
                             kind, ch, last, trunc);
                end
                return;
            end
            want = pending_tokens.pop_front();
            if (want.kind !== kind || want.ch !== ch || want.last !== last
                    || want.trunc !== trunc) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result %0d: expected kind %0d char %h last %b trunc %b",
                             results_checked, want.kind, want.ch, want.last, want.trunc);
                    $display("    got kind %0d char %h last %b trunc %b",
                             kind, ch, last, trunc);
                end
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   cycles = 0;
    bit   src_calm = 1'b0;
    bit   snk_calm = 1'b0;
    bit   drain_next = 1'b0;

    t_char_request char_requests[$];
    token_tracker  tracker = new();

    lts_in_if  req_if();
    lts_out_if res_if();

    lexical_token_scanner #(
        .MAX_TOKEN_CHARS(MAX_TOKEN_CHARS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_req(req_if),
        .o_res(res_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("[lexical_token_scanner] ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            tracker.check_token_result(res_if.token_kind, res_if.char_value,
                                       res_if.last_of_run, res_if.truncated);
        end
    end

    function void add_char(logic [7:0] c, bit eoi = 1'b0);
        t_char_request r;
        r.code = c;
        r.eoi = eoi;
        r.drain = drain_next;
        drain_next = 1'b0;
        char_requests.push_back(r);
    endfunction

    function void add_text(string s);
        int i;
        for (i = 0; i < s.len(); i++) add_char(8'(s[i]));
    endfunction

    function logic [7:0] random_letter();
        if ($urandom_range(0, 1)) return 8'(lts_pkg::CH_LOWER_A + $urandom_range(0, 25));
        return 8'(lts_pkg::CH_UPPER_A + $urandom_range(0, 25));
    endfunction

    function logic [7:0] random_digit();
        return 8'(lts_pkg::CH_ZERO + $urandom_range(0, 9));
    endfunction

    // Mostly short tokens; now and then a long one that can overflow the buffer.
    function int token_size();
        if ($urandom_range(0, 11) == 0) return $urandom_range(17, 26);
        return $urandom_range(1, 7);
    endfunction

    function void add_random_token();
        string words [5];
        string ops [6];
        string blanks;
        int    pick;
        int    n;
        int    i;
        words = '{"begin", "end", "if", "then", "else"};
        ops = '{"<", "<=", "<>", "=", ">", ">="};
        blanks = " \t\n";
        pick = $urandom_range(0, 19);
        if (pick < 3) begin
            add_text(words[$urandom_range(0, 4)]);
        end else if (pick < 7) begin
            n = token_size();
            add_char(random_letter());
            for (i = 1; i < n; i++) begin
                add_char($urandom_range(0, 2) ? random_letter() : random_digit());
            end
        end else if (pick < 9) begin
            n = token_size();
            for (i = 0; i < n; i++) add_char(random_digit());
        end else if (pick < 11) begin
            n = token_size();
            for (i = 0; i < n; i++) add_char(random_digit());
            add_char(lts_pkg::CH_DOT);
            n = $urandom_range(0, 5);
            for (i = 0; i < n; i++) add_char(random_digit());
            if ($urandom_range(0, 3) == 0) add_char(lts_pkg::CH_DOT);
        end else if (pick < 15) begin
            add_text(ops[$urandom_range(0, 5)]);
        end else if (pick < 17) begin
            add_char(8'($urandom_range(0, 255)));
        end else if (pick < 19) begin
            add_char(8'(blanks[$urandom_range(0, 2)]));
        end else begin
            add_char(8'($urandom_range(0, 255)), 1'b1);
        end
        if ($urandom_range(0, 9) < 6) add_char(8'(blanks[$urandom_range(0, 2)]));
    endfunction

    task automatic send_requests();
        t_char_request r;
        int            gap;
        foreach (char_requests[i]) begin
            r = char_requests[i];
            gap = src_calm ? 0 : $urandom_range(0, 9);
            if ($urandom_range(0, 19) == 0) src_calm = !src_calm;
            if (r.drain && gap == 0) gap = 1;
            if (gap > 0) begin
                req_if.valid <= 1'b0;
                if (r.drain) begin
                    while (tracker.pending_tokens.size() != 0) @(posedge i_clk);
                end
                repeat (gap) @(posedge i_clk);
            end
            req_if.valid <= 1'b1;
            req_if.char_code <= r.code;
            req_if.end_of_input <= r.eoi;
            do @(posedge i_clk); while (!req_if.ready);
            tracker.take_char(r.code, r.eoi);
        end
        req_if.valid <= 1'b0;
    endtask

    task automatic accept_results();
        int stall;
        res_if.ready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = snk_calm ? 0 : $urandom_range(0, 9);
            if ($urandom_range(0, 19) == 0) snk_calm = !snk_calm;
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (!res_if.valid);
        end
    endtask

    initial begin
        accept_results();
    end

    initial begin
        int directed;
        req_if.valid <= 1'b0;
        req_if.char_code <= 8'h00;
        req_if.end_of_input <= 1'b0;

        // Keyword, float cut by a second dot, number followed by a letter, every
        // operator but >=, bytes at both ends of the range, end of input while idle
        // and with an operator pending.
        add_text("if\t12.3.4a<=>x<>=\n");
        add_char(8'hFF);
        add_char(8'h00);
        add_char(8'hFF, 1'b1);
        add_char(lts_pkg::CH_LT);
        add_char(8'h00, 1'b1);
        add_char(lts_pkg::CH_GT);
        add_char(8'h7F, 1'b1);
        directed = char_requests.size();

        drain_next = 1'b1;
        while (char_requests.size() < directed + RANDOM_REQUESTS) begin
            if ($urandom_range(0, 59) == 0) drain_next = 1'b1;
            add_random_token();
        end
        add_char(8'($urandom_range(0, 255)), 1'b1);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_requests();
        while (tracker.pending_tokens.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("scanned %0d characters into %0d results; %0d of 15 token kinds seen",
                 tracker.chars_taken, tracker.results_checked, $countones(tracker.kinds_seen));
        $display("%0d results came from truncated tokens", tracker.truncated_results);
        if (tracker.mismatches == 0 && tracker.pending_tokens.size() == 0) begin
            $display("[lexical_token_scanner] OK");
        end else begin
            $display("%0d mismatches, %0d results never arrived",
                     tracker.mismatches, tracker.pending_tokens.size());
            $display("[lexical_token_scanner] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
